// File: hdl/nsp_pkg.sv
// shared types and constants of the nearest speaker panner
package nsp_pkg;

    localparam int SMP_W     = 24;
    localparam int DIR_W     = 16;
    localparam int IDX_W     = 3;
    localparam int WGT_W     = 26;
    localparam int RAMP_W    = 17;
    localparam int DOT_W     = 2 * DIR_W + 1;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = RAMP_W;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_DIR    = 2'd1;
    localparam logic [1:0] OP_SPK_WR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_USE_ALL   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP = 1'd1;

    localparam logic [RAMP_W-1:0] RAMP_RESET = 17'd64;

    localparam logic signed [WGT_W:0]   UNITY_Q24 = 27'sd16777216;
    localparam logic signed [WGT_W-1:0] W_MAX     = 26'sh1ffffff;
    localparam logic signed [WGT_W-1:0] W_MIN     = 26'sh2000000;
    localparam logic signed [SMP_W-1:0] S24_MAX   = 24'sh7fffff;
    localparam logic signed [SMP_W-1:0] S24_MIN   = 24'sh800000;

    typedef struct packed {
        logic        [1:0]       op;
        logic signed [SMP_W-1:0] sample;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
        logic        [IDX_W-1:0] speaker_index;
    } t_in_item;

    typedef struct packed {
        logic        [IDX_W-1:0] speaker;
        logic signed [SMP_W-1:0] contribution;
        logic                    last;
    } t_out_item;

    typedef struct packed {
        logic signed [DIR_W-1:0] x;
        logic signed [DIR_W-1:0] y;
        logic signed [DIR_W-1:0] z;
    } t_vec;

    typedef struct packed {
        logic signed [WGT_W-1:0] weight;
        logic signed [WGT_W-1:0] step;
    } t_ws;

endpackage

// File: hdl/nsp_dot.sv
// three-term dot product of source and speaker directions, products registered
module nsp_dot (
    input  logic                              i_clk,
    input  nsp_pkg::t_vec                     i_src,
    input  nsp_pkg::t_vec                     i_spk,
    output logic signed [nsp_pkg::DOT_W-1:0]  o_dot
);
    import nsp_pkg::*;

    logic signed [2*DIR_W-1:0] r_px;
    logic signed [2*DIR_W-1:0] r_py;
    logic signed [2*DIR_W-1:0] r_pz;

    always_ff @(posedge i_clk) begin
        r_px <= i_src.x * i_spk.x;
        r_py <= i_src.y * i_spk.y;
        r_pz <= i_src.z * i_spk.z;
    end

    assign o_dot = {r_px[2*DIR_W-1], r_px} + {r_py[2*DIR_W-1], r_py}
                 + {r_pz[2*DIR_W-1], r_pz};

endmodule

// File: hdl/nearest_speaker_panner_top.sv
// top level of the nearest speaker panner
// Sends a point source to the loudspeaker whose stored direction has the largest dot
// product with the source direction, ramping every speaker gain linearly toward its
// target. A speaker write is taken in the idle state, and the next item can follow
// at once. A direction item first searches, passing each speaker through the read,
// multiply and compare states, then recomputes the weight steps, passing each speaker
// through the read, subtract, multiply and write states; only then is the next item
// taken. A sample item passes each speaker through the read, add, multiply and output
// states, and the output state waits while the output is stalled. The sequencer reads
// each entry of the weight memory through its single port, works on it in the following
// states and writes it back. The weight and step memory starts at zero through per-entry
// valid bits, so no clearing pass is needed after reset. A new item is taken while the
// last result still waits in the output register.
module nearest_speaker_panner_top #(
    parameter int NUM_SPEAKERS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  nsp_pkg::t_in_item                 i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output nsp_pkg::t_out_item                o_out_item,
    input  logic                              i_cfg_we,
    input  logic [nsp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [nsp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import nsp_pkg::*;

    localparam int IW = (NUM_SPEAKERS > 1) ? $clog2(NUM_SPEAKERS) : 1;
    localparam logic [IW-1:0] K_LAST = IW'(NUM_SPEAKERS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIR_RD,
        S_DIR_MUL,
        S_DIR_CMP,
        S_STP_RD,
        S_STP_SUB,
        S_STP_MUL,
        S_STP_WR,
        S_SMP_RD,
        S_SMP_ADD,
        S_SMP_MUL,
        S_SMP_OUT
    } t_state;

    t_state                    r_state;
    logic [IW-1:0]             r_k;
    logic [IW-1:0]             r_best;
    logic signed [DOT_W-1:0]   r_best_dot;
    logic                      r_use_all;
    logic [RAMP_W-1:0]         r_ramp;
    logic                      r_out_valid;
    t_out_item                 r_out_item;
    t_vec                      r_src;
    logic signed [SMP_W-1:0]   r_smp;
    logic signed [WGT_W-1:0]   r_w;
    logic signed [WGT_W:0]     r_diff;
    logic signed [WGT_W+RAMP_W+1:0] r_sprod;
    logic signed [WGT_W+SMP_W-1:0]  r_cprod;

    t_vec                      r_dir_mem [NUM_SPEAKERS];
    t_ws                       r_ws_mem [NUM_SPEAKERS];
    logic [NUM_SPEAKERS-1:0]   r_ws_vld;
    t_vec                      r_dir_rd;
    t_ws                       r_ws_rd;
    logic                      r_ws_rd_vld;

    logic                      in_take;
    logic                      out_free;
    logic                      out_load;
    logic                      dir_we;
    logic [IW-1:0]             dir_wa;
    logic                      ws_we;
    t_ws                       ws_wd;
    logic signed [DOT_W-1:0]   dot;
    logic signed [WGT_W-1:0]   w_cur;
    logic signed [WGT_W-1:0]   st_cur;
    logic signed [WGT_W:0]     w_sum;
    logic signed [WGT_W-1:0]   w_new;
    logic                      target_one;
    logic signed [WGT_W:0]     diff;
    logic signed [WGT_W+RAMP_W+2:0] sprod_rnd;
    logic signed [WGT_W-1:0]   step_new;
    logic signed [WGT_W+SMP_W:0]    cprod_rnd;
    logic signed [SMP_W-1:0]   contrib;
    logic                      k_last;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = (r_state == S_SMP_OUT) && out_free;
    assign k_last   = (r_k == K_LAST);

    // speaker direction store
    assign dir_we = in_take && (i_in_item.op == OP_SPK_WR)
                 && (int'(i_in_item.speaker_index) < NUM_SPEAKERS);
    assign dir_wa = IW'(i_in_item.speaker_index);

    always_ff @(posedge i_clk) begin
        if (dir_we) begin
            r_dir_mem[dir_wa] <= '{x: i_in_item.dir_x, y: i_in_item.dir_y,
                                   z: i_in_item.dir_z};
        end
        r_dir_rd <= r_dir_mem[r_k];
    end

    // weight and step store
    always_ff @(posedge i_clk) begin
        if (ws_we) begin
            r_ws_mem[r_k] <= ws_wd;
        end
        r_ws_rd     <= r_ws_mem[r_k];
        r_ws_rd_vld <= r_ws_vld[r_k];
    end

    nsp_dot u_dot (
        .i_clk (i_clk),
        .i_src (r_src),
        .i_spk (r_dir_rd),
        .o_dot (dot)
    );

    assign w_cur  = r_ws_rd_vld ? r_ws_rd.weight : '0;
    assign st_cur = r_ws_rd_vld ? r_ws_rd.step : '0;

    // weight advance with saturation
    assign w_sum = {w_cur[WGT_W-1], w_cur} + {st_cur[WGT_W-1], st_cur};
    always_comb begin
        if (w_sum[WGT_W] == w_sum[WGT_W-1]) begin
            w_new = w_sum[WGT_W-1:0];
        end else begin
            w_new = w_sum[WGT_W] ? W_MIN : W_MAX;
        end
    end

    // step toward target
    assign target_one = r_use_all || (r_k == r_best);
    assign diff = (target_one ? UNITY_Q24 : '0) - {w_cur[WGT_W-1], w_cur};
    assign sprod_rnd = {r_sprod[WGT_W+RAMP_W+1], r_sprod}
                     + (WGT_W+RAMP_W+3)'(32'sd32768);
    always_comb begin
        if (&sprod_rnd[WGT_W+RAMP_W+2:WGT_W+15]
            || ~|sprod_rnd[WGT_W+RAMP_W+2:WGT_W+15]) begin
            step_new = sprod_rnd[WGT_W+15:16];
        end else begin
            step_new = sprod_rnd[WGT_W+RAMP_W+2] ? W_MIN : W_MAX;
        end
    end

    // weighted sample
    assign cprod_rnd = {r_cprod[WGT_W+SMP_W-1], r_cprod}
                     + (WGT_W+SMP_W+1)'(32'sd8388608);
    always_comb begin
        if (&cprod_rnd[WGT_W+SMP_W:SMP_W+23] || ~|cprod_rnd[WGT_W+SMP_W:SMP_W+23]) begin
            contrib = cprod_rnd[SMP_W+23:24];
        end else begin
            contrib = cprod_rnd[WGT_W+SMP_W] ? S24_MIN : S24_MAX;
        end
    end

    assign ws_we = (r_state == S_STP_WR) || (r_state == S_SMP_ADD);
    always_comb begin
        if (r_state == S_STP_WR) begin
            ws_wd = '{weight: r_w, step: step_new};
        end else begin
            ws_wd = '{weight: w_new, step: st_cur};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_best      <= '0;
            r_use_all   <= 1'b0;
            r_ramp      <= RAMP_RESET;
            r_out_valid <= 1'b0;
            r_ws_vld    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_USE_ALL:   r_use_all <= i_cfg_data[0];
                    REG_RAMP_STEP: r_ramp    <= i_cfg_data;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_smp <= i_in_item.sample;
                        r_src <= '{x: i_in_item.dir_x, y: i_in_item.dir_y,
                                   z: i_in_item.dir_z};
                        r_k   <= '0;
                        if (i_in_item.op == OP_SAMPLE) begin
                            r_state <= S_SMP_RD;
                        end else if (i_in_item.op == OP_DIR) begin
                            r_state <= S_DIR_RD;
                        end
                    end
                end
                S_DIR_RD: r_state <= S_DIR_MUL;
                S_DIR_MUL: r_state <= S_DIR_CMP;
                S_DIR_CMP: begin
                    if ((r_k == '0) || (dot > r_best_dot)) begin
                        r_best     <= r_k;
                        r_best_dot <= dot;
                    end
                    if (k_last) begin
                        r_k     <= '0;
                        r_state <= S_STP_RD;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_DIR_RD;
                    end
                end
                S_STP_RD: r_state <= S_STP_SUB;
                S_STP_SUB: begin
                    r_w     <= w_cur;
                    r_diff  <= diff;
                    r_state <= S_STP_MUL;
                end
                S_STP_MUL: begin
                    r_sprod <= r_diff * $signed({1'b0, r_ramp});
                    r_state <= S_STP_WR;
                end
                S_STP_WR: begin
                    r_ws_vld[r_k] <= 1'b1;
                    if (k_last) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_STP_RD;
                    end
                end
                S_SMP_RD: r_state <= S_SMP_ADD;
                S_SMP_ADD: begin
                    r_w           <= w_new;
                    r_ws_vld[r_k] <= 1'b1;
                    r_state       <= S_SMP_MUL;
                end
                S_SMP_MUL: begin
                    r_cprod <= r_w * r_smp;
                    r_state <= S_SMP_OUT;
                end
                S_SMP_OUT: begin
                    if (out_load) begin
                        r_out_item.speaker      <= IDX_W'(r_k);
                        r_out_item.contribution <= contrib;
                        r_out_item.last         <= k_last;
                        if (k_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_SMP_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: verif/tb_top.sv
// self-checking testbench of the nearest speaker panner top level
`timescale 1ns / 1ps

module tb_top;
    import nsp_pkg::*;

    localparam int NSPK      = 8;
    localparam int SETTLE    = 90;
    localparam int HOLD_LEN  = 400;
    localparam logic [1:0] OP_RSVD = 2'd3;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    t_in_item           i_in_item  = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_item          o_out_item;
    logic               i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    nearest_speaker_panner_top #(
        .NUM_SPEAKERS(NSPK)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // panner state as predicted
    t_vec                    spk_dir  [NSPK];
    logic signed [WGT_W-1:0] spk_wgt  [NSPK];
    logic signed [WGT_W-1:0] spk_step [NSPK];
    logic                    use_all_q = 1'b0;
    logic [RAMP_W-1:0]       ramp_q    = RAMP_RESET;

    t_in_item  item_q[$];
    t_out_item contrib_q[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_tokens = 0;
    int hold_done = 0;
    int hold_cnt = 0;
    bit in_took = 1'b0;

    int n_err = 0;
    int n_smp = 0;
    int n_dir = 0;
    int n_wr = 0;
    int n_rsv = 0;
    int n_res = 0;
    int n_settings = 1;
    t_out_item got_r;
    t_out_item exp_r;

    function automatic longint round_shr(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    task automatic pan_predict(input t_in_item it);
        longint dot;
        longint best_dot;
        longint tgt;
        longint w;
        longint c;
        int best;
        t_out_item r;
        best = 0;
        best_dot = 0;
        case (it.op)
            OP_SPK_WR: begin
                spk_dir[it.speaker_index] = '{x: it.dir_x, y: it.dir_y, z: it.dir_z};
            end
            OP_DIR: begin
                for (int k = 0; k < NSPK; k++) begin
                    dot = longint'($signed(it.dir_x)) * longint'($signed(spk_dir[k].x))
                        + longint'($signed(it.dir_y)) * longint'($signed(spk_dir[k].y))
                        + longint'($signed(it.dir_z)) * longint'($signed(spk_dir[k].z));
                    if (k == 0 || dot > best_dot) begin
                        best = k;
                        best_dot = dot;
                    end
                end
                for (int k = 0; k < NSPK; k++) begin
                    tgt = (use_all_q || k == best) ? longint'(UNITY_Q24) : 0;
                    w = round_shr((tgt - longint'(spk_wgt[k])) * longint'(ramp_q), 16);
                    spk_step[k] = WGT_W'(clip(w, longint'(W_MIN), longint'(W_MAX)));
                end
            end
            OP_SAMPLE: begin
                for (int k = 0; k < NSPK; k++) begin
                    w = clip(longint'(spk_wgt[k]) + longint'(spk_step[k]),
                             longint'(W_MIN), longint'(W_MAX));
                    spk_wgt[k] = WGT_W'(w);
                    c = clip(round_shr(w * longint'($signed(it.sample)), 24),
                             longint'(S24_MIN), longint'(S24_MAX));
                    r.speaker = IDX_W'(k);
                    r.contribution = SMP_W'(c);
                    r.last = (k == NSPK - 1);
                    contrib_q.push_back(r);
                end
            end
            default: begin
            end
        endcase
    endtask

    // input side: a transfer happens where valid is high and stall is low
    always @(posedge i_clk) begin
        in_took = i_rst_n && i_in_valid && !o_in_stall;
        if (in_took) begin
            case (i_in_item.op)
                OP_SAMPLE: n_smp++;
                OP_DIR:    n_dir++;
                OP_SPK_WR: n_wr++;
                default:   n_rsv++;
            endcase
            pan_predict(i_in_item);
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_took) begin
            if (item_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_item  <= item_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output side
    always @(negedge i_clk) begin
        if (hold_cnt != 0) begin
            i_out_stall <= 1'b1;
            hold_cnt <= hold_cnt - 1;
        end else if (hold_done != hold_tokens) begin
            i_out_stall <= 1'b1;
            hold_cnt <= HOLD_LEN;
            hold_done <= hold_done + 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got_r = o_out_item;
            if (contrib_q.size() == 0) begin
                $error("unexpected transfer: speaker %0d contribution %0d last %0d",
                       got_r.speaker, got_r.contribution, got_r.last);
                n_err++;
            end else begin
                exp_r = contrib_q.pop_front();
                n_res++;
                if (got_r.speaker !== exp_r.speaker) begin
                    $error("speaker: expected %0d, got %0d", exp_r.speaker, got_r.speaker);
                    n_err++;
                end
                if (got_r.contribution !== exp_r.contribution) begin
                    $error("contribution: expected %0d, got %0d",
                           exp_r.contribution, got_r.contribution);
                    n_err++;
                end
                if (got_r.last !== exp_r.last) begin
                    $error("last: expected %0d, got %0d", exp_r.last, got_r.last);
                    n_err++;
                end
            end
        end
    end

    function automatic t_in_item mk_item(logic [1:0] op, int smp, int x, int y, int z,
                                         int idx);
        t_in_item it;
        it.op = op;
        it.sample = SMP_W'(smp);
        it.dir_x = DIR_W'(x);
        it.dir_y = DIR_W'(y);
        it.dir_z = DIR_W'(z);
        it.speaker_index = IDX_W'(idx);
        return it;
    endfunction

    function automatic logic signed [DIR_W-1:0] rand_comp();
        int pick;
        pick = $urandom_range(15);
        if (pick == 0) return DIR_W'(-32768);
        if (pick == 1) return DIR_W'(32767);
        if (pick == 2) return '0;
        return DIR_W'($urandom);
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        int pick;
        pick = $urandom_range(99);
        it.op = (pick < 55) ? OP_SAMPLE : (pick < 75) ? OP_DIR :
                (pick < 90) ? OP_SPK_WR : OP_RSVD;
        pick = $urandom_range(9);
        it.sample = (pick == 0) ? 24'sh7fffff : (pick == 1) ? 24'sh800000 :
                    SMP_W'($urandom);
        it.dir_x = rand_comp();
        it.dir_y = rand_comp();
        it.dir_z = rand_comp();
        it.speaker_index = IDX_W'($urandom);
        return it;
    endfunction

    task automatic push_random(int n);
        t_in_item it;
        int cnt;
        cnt = 0;
        while (cnt < n) begin
            it = rand_item();
            item_q.push_back(it);
            if (it.op != OP_RSVD) cnt++;
        end
    endtask

    task automatic wait_drained();
        while (item_q.size() != 0 || i_in_valid || contrib_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_USE_ALL) use_all_q = val[0];
        else ramp_q = val;
    endtask

    task automatic run_phase(logic ua, logic [RAMP_W-1:0] ramp, int in_pct, int out_pct,
                             int n, bit hold, bit pause);
        wait_drained();
        write_reg(REG_USE_ALL, CFG_DATA_W'(ua));
        write_reg(REG_RAMP_STEP, ramp);
        n_settings++;
        send_idle_pct = in_pct;
        recv_stall_pct = out_pct;
        if (hold) begin
            @(posedge i_clk);
            hold_tokens++;
        end
        if (pause) begin
            push_random(n / 2);
            wait_drained();
            push_random(n - n / 2);
        end else begin
            push_random(n);
        end
    endtask

    initial begin
        for (int k = 0; k < NSPK; k++) begin
            spk_dir[k] = '0;
            spk_wgt[k] = '0;
            spk_step[k] = '0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part under the reset settings
        item_q.push_back(mk_item(OP_SAMPLE, 8388607, 0, 0, 0, 0));
        item_q.push_back(mk_item(OP_SPK_WR, 0, 32767, 0, 0, 0));
        item_q.push_back(mk_item(OP_SPK_WR, 0, -32768, 0, 0, 1));
        item_q.push_back(mk_item(OP_SPK_WR, 0, 0, 32767, 0, 2));
        item_q.push_back(mk_item(OP_SPK_WR, 0, 0, -32768, 0, 3));
        item_q.push_back(mk_item(OP_SPK_WR, 0, 0, 0, 32767, 4));
        item_q.push_back(mk_item(OP_SPK_WR, 0, 0, 0, -32768, 5));
        item_q.push_back(mk_item(OP_SPK_WR, 0, 23170, 23170, 0, 6));
        item_q.push_back(mk_item(OP_SPK_WR, 0, -23170, 0, -23170, 7));
        item_q.push_back(mk_item(OP_RSVD, -8388608, -1, -1, -1, 7));
        // zero source vector
        item_q.push_back(mk_item(OP_DIR, -1, 0, 0, 0, 5));
        item_q.push_back(mk_item(OP_SAMPLE, 8388607, 0, 0, 0, 0));
        item_q.push_back(mk_item(OP_SAMPLE, -8388608, -1, -1, -1, 7));
        item_q.push_back(mk_item(OP_SAMPLE, 0, 0, 0, 0, 0));
        item_q.push_back(mk_item(OP_SAMPLE, -1, 0, 0, 0, 0));
        // equal dot product on speakers 2 and 4
        item_q.push_back(mk_item(OP_DIR, 0, 0, 32767, 32767, 0));
        item_q.push_back(mk_item(OP_SAMPLE, 4194304, 0, 0, 0, 0));
        item_q.push_back(mk_item(OP_SAMPLE, -4194305, 0, 0, 0, 0));
        item_q.push_back(mk_item(OP_DIR, 0, -32768, -32768, -32768, 0));
        item_q.push_back(mk_item(OP_SAMPLE, 8388607, 0, 0, 0, 0));
        item_q.push_back(mk_item(OP_SPK_WR, 0, 100, -200, 300, 3));
        item_q.push_back(mk_item(OP_DIR, 0, 32767, -32768, 32767, 0));
        item_q.push_back(mk_item(OP_SAMPLE, -8388608, 0, 0, 0, 0));

        run_phase(1'b0, 17'd65536, 77, 0, 24, 1'b0, 1'b0);
        run_phase(1'b1, 17'd1, 0, 77, 22, 1'b1, 1'b0);
        run_phase(1'b0, 17'h1ffff, 7, 7, 24, 1'b0, 1'b1);
        run_phase(1'($urandom), RAMP_W'($urandom_range(65536, 1)), 0, 0, 18, 1'b0, 1'b0);
        run_phase(1'b1, 17'd0, 77, 77, 10, 1'b0, 1'b0);
        wait_drained();

        $display("tb_top: %0d samples, %0d source directions, %0d speaker writes, %0d ignored",
                 n_smp, n_dir, n_wr, n_rsv);
        $display("tb_top: %0d contributions checked over %0d register settings",
                 n_res, n_settings);
        if (n_err == 0 && contrib_q.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
